/* rtl/ffp_pkg.sv */
// ----------------------------------------------------------------------------
// ffp_pkg
// types and constants shared by the flow frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'hFE;
  localparam logic [7:0] FTR_BYTE   = 8'hAA;
  localparam logic [7:0] FOLD_LIMIT = 8'd127;

  typedef enum logic [3:0] {
    POS_HDR  = 4'd0,
    POS_RSV  = 4'd1,
    POS_XLO  = 4'd2,
    POS_XHI  = 4'd3,
    POS_YLO  = 4'd4,
    POS_YHI  = 4'd5,
    POS_T    = 4'd6,
    POS_Q    = 4'd7,
    POS_FTR  = 4'd8
  } pos_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } byte_t;

  typedef struct packed {
    logic signed [15:0] motion_x;
    logic signed [15:0] motion_y;
    logic        [7:0]  fold_t;
    logic        [7:0]  quality;
  } res_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b > FOLD_LIMIT) begin
      v = 8'd0 - b;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/ffp_if.sv */
// ----------------------------------------------------------------------------
// ffp_in_if / ffp_out_if
// valid/ready channels for received bytes and parsed motion items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ffp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motion_x;
  logic signed [15:0] motion_y;
  logic        [7:0]  fold_t;
  logic        [7:0]  quality;

  modport source (output valid, output motion_x, output motion_y, output fold_t,
                  output quality, input ready);
  modport sink   (input valid, input motion_x, input motion_y, input fold_t,
                  input quality, output ready);
endinterface

`default_nettype wire

/* rtl/ffp_in_stage.sv */
// ----------------------------------------------------------------------------
// ffp_in_stage
// input register for received bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffp_in_stage
  import ffp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ffp_in_if.sink    in_ch,
  input  wire logic advance,
  output byte_t     stage
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;
  logic       take;

  assign in_ch.ready = !vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (take) begin
      vld_nxt  = 1'b1;
      data_nxt = in_ch.rx_byte;
    end else if (advance) begin
      vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign stage.vld  = vld_r;
  assign stage.data = data_r;

endmodule

`default_nettype wire

/* rtl/ffp_parse.sv */
// ----------------------------------------------------------------------------
// ffp_parse
// frame position tracking and field assembly
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffp_parse
  import ffp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire byte_t stage,
  input  wire logic  advance,
  output logic       res_vld,
  output res_t       res
);

  pos_t        pos_r, pos_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [7:0]  t_r, t_nxt;
  logic [7:0]  q_r, q_nxt;
  logic        fire;

  assign fire = stage.vld && advance;

  always_comb begin
    pos_nxt = pos_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    t_nxt   = t_r;
    q_nxt   = q_r;
    res_vld = 1'b0;
    if (fire) begin
      unique case (pos_r)
        POS_HDR: begin
          pos_nxt = (stage.data == HDR_BYTE) ? POS_RSV : POS_HDR;
        end
        POS_RSV: begin
          pos_nxt = POS_XLO;
        end
        POS_XLO: begin
          x_nxt   = {8'd0, stage.data};
          pos_nxt = POS_XHI;
        end
        POS_XHI: begin
          x_nxt   = {stage.data, x_r[7:0]};
          pos_nxt = POS_YLO;
        end
        POS_YLO: begin
          y_nxt   = {8'd0, stage.data};
          pos_nxt = POS_YHI;
        end
        POS_YHI: begin
          y_nxt   = {stage.data, y_r[7:0]};
          pos_nxt = POS_T;
        end
        POS_T: begin
          t_nxt   = fold_byte(stage.data);
          pos_nxt = POS_Q;
        end
        POS_Q: begin
          q_nxt   = stage.data;
          pos_nxt = POS_FTR;
        end
        POS_FTR: begin
          res_vld = (stage.data == FTR_BYTE);
          pos_nxt = POS_HDR;
        end
        default: begin
          pos_nxt = POS_HDR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR;
      x_r   <= 16'd0;
      y_r   <= 16'd0;
      t_r   <= 8'd0;
      q_r   <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      t_r   <= t_nxt;
      q_r   <= q_nxt;
    end
  end

  assign res.motion_x = x_r;
  assign res.motion_y = y_r;
  assign res.fold_t   = t_r;
  assign res.quality  = q_r;

endmodule

`default_nettype wire

/* rtl/ffp_out_stage.sv */
// ----------------------------------------------------------------------------
// ffp_out_stage
// result register driving the motion item channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffp_out_stage
  import ffp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  res_vld,
  input  wire res_t  res,
  output logic       advance,
  ffp_out_if.source  out_ch
);

  logic vld_r, vld_nxt;
  res_t res_r, res_nxt;

  assign advance = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
      res_nxt = res;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid    = vld_r;
  assign out_ch.motion_x = res_r.motion_x;
  assign out_ch.motion_y = res_r.motion_y;
  assign out_ch.fold_t   = res_r.fold_t;
  assign out_ch.quality  = res_r.quality;

endmodule

`default_nettype wire

/* rtl/flow_frame_parser.sv */
// ----------------------------------------------------------------------------
// flow_frame_parser
// parses nine-byte optical flow frames into motion items
// ----------------------------------------------------------------------------
// path: a footer byte is held in the input register, its item then in the
// result register; throughput: one byte per cycle unless the output stalls,
// set by the single parse stage between the input and result registers
// reset: synchronous active-low rst_n clears frame position, held fields
// and both valid flags; the parser then waits for a header
`timescale 1ns / 1ps
`default_nettype none

module flow_frame_parser
  import ffp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ffp_in_if.sink    in_ch,
  ffp_out_if.source out_ch
);

  byte_t stage;
  logic  advance;
  logic  res_vld;
  res_t  res;

  ffp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  ffp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .res_vld (res_vld),
    .res     (res)
  );

  ffp_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_vld (res_vld),
    .res     (res),
    .advance (advance),
    .out_ch  (out_ch)
  );

  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> out_ch.valid && out_ch.motion_x == $past(res.motion_x)
      && out_ch.quality == $past(res.quality))
    else $error("parsed item not loaded into result register");

  a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> advance && stage.vld && stage.data == FTR_BYTE)
    else $error("item produced without footer or without room");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.vld && !advance) |-> !in_ch.ready)
    else $error("input accepted while held byte is stalled");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.vld && !advance) |=> stage.vld && stage.data == $past(stage.data))
    else $error("stalled byte lost");

endmodule

`default_nettype wire

/* tb/tb_flow_frame_parser.sv */
// ----------------------------------------------------------------------------
// tb_flow_frame_parser
// Feeds serial bytes into the flow frame parser and checks every motion item
// against a cycle-free frame predictor kept in the bench. A short directed
// run covers field extremes, a stray byte before a header, the reserved byte,
// a bad footer that looks like a header and held fields from a dropped frame.
// Random traffic follows: mostly well-formed frames with random content,
// mixed with cut-off frames, bad footers and stray bytes. Both sides idle at
// random, with a stretch of no idling and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_flow_frame_parser
  import ffp_pkg::*;
();

  localparam int CYCLE_LIMIT  = 60000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 13;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffp_in_if  in_ch ();
  ffp_out_if out_ch ();

  flow_frame_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0] byte_q[$];
  res_t       motion_due[$];
  logic       in_took = 1'b0;
  logic       calm = 1'b0;
  logic       hold_go = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;
  int         errors = 0;
  int         cyc = 0;

  // frame tracker state
  logic [3:0]  frame_pos = POS_HDR;
  logic [15:0] x_acc = '0;
  logic [15:0] y_acc = '0;
  logic [7:0]  t_acc = '0;
  logic [7:0]  q_acc = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void advance_frame(input logic [7:0] c);
    logic [3:0] nxt;
    res_t       r;
    nxt = frame_pos + 4'd1;
    case (frame_pos)
      POS_HDR: if (c != HDR_BYTE) nxt = POS_HDR;
      POS_RSV: ;
      POS_XLO: x_acc = {8'h00, c};
      POS_XHI: x_acc[15:8] = c;
      POS_YLO: y_acc = {8'h00, c};
      POS_YHI: y_acc[15:8] = c;
      POS_T:   t_acc = c[7] ? (~c) + 8'd1 : c;
      POS_Q:   q_acc = c;
      POS_FTR: begin
        if (c == FTR_BYTE) begin
          r.motion_x = x_acc;
          r.motion_y = y_acc;
          r.fold_t   = t_acc;
          r.quality  = q_acc;
          motion_due.push_back(r);
        end
        nxt = POS_HDR;
      end
      default: nxt = POS_HDR;
    endcase
    frame_pos = nxt;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    errors++;
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
  endtask

  task automatic push_frame(input logic [7:0] rsv, input logic [15:0] x,
                            input logic [15:0] y, input logic [7:0] t,
                            input logic [7:0] q, input logic [7:0] ftr,
                            input int upto);
    logic [7:0] frame [9];
    frame = '{HDR_BYTE, rsv, x[7:0], x[15:8], y[7:0], y[15:8], t, q, ftr};
    for (int i = 0; i < upto; i++) begin
      byte_q.push_back(frame[i]);
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_traffic(input int budget);
    int         sent;
    int         pick;
    int         k;
    logic [7:0] ftr;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        push_frame(8'($urandom), pick_word(), pick_word(), 8'($urandom),
                   8'($urandom), FTR_BYTE, 9);
        sent += 9;
      end else if (pick < 86) begin
        ftr = ($urandom_range(0, 1) != 0) ? HDR_BYTE : 8'($urandom);
        if (ftr == FTR_BYTE) ftr = HDR_BYTE;
        push_frame(8'($urandom), pick_word(), pick_word(), 8'($urandom),
                   8'($urandom), ftr, 9);
        sent += 9;
      end else if (pick < 93) begin
        k = $urandom_range(1, 8);
        push_frame(8'($urandom), pick_word(), pick_word(), 8'($urandom),
                   8'($urandom), FTR_BYTE, k);
        sent += k;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          byte_q.push_back(($urandom_range(0, 1) != 0) ? FTR_BYTE : 8'($urandom));
        end
      end
    end
  endtask

  task automatic wait_sent();
    while (byte_q.size() != 0) @(posedge clk);
  endtask

  // byte source
  always @(negedge clk) begin : feed
    logic go;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_took) void'(byte_q.pop_front());
      if (in_ch.valid && !in_took) begin
        go = 1'b1;
      end else begin
        go = byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT);
      end
      in_ch.valid <= go;
      in_ch.rx_byte <= go ? byte_q[0] : 8'($urandom);
    end
  end

  // long output stall counter
  always @(negedge clk) begin : hold_timer
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // motion item sink
  always @(negedge clk) begin : take_side
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin : watch
    res_t want;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) advance_frame(in_ch.rx_byte);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (motion_due.size() == 0) begin
        flag_mismatch("unexpected item motion_x", out_ch.motion_x, 16'h0000);
      end else begin
        want = motion_due.pop_front();
        if (out_ch.motion_x !== want.motion_x)
          flag_mismatch("motion_x", out_ch.motion_x, want.motion_x);
        if (out_ch.motion_y !== want.motion_y)
          flag_mismatch("motion_y", out_ch.motion_y, want.motion_y);
        if (out_ch.fold_t !== want.fold_t)
          flag_mismatch("fold_t", 16'(out_ch.fold_t), 16'(want.fold_t));
        if (out_ch.quality !== want.quality)
          flag_mismatch("quality", 16'(out_ch.quality), 16'(want.quality));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray byte before any header
    byte_q.push_back(8'h00);
    // extremes: most negative x, most positive y, t folding to 128
    push_frame(8'hFF, 16'h8000, 16'h7FFF, 8'h80, 8'hFF, FTR_BYTE, 9);
    // bad footer that looks like a header, then held fields overwritten
    push_frame(8'h00, 16'hFFFF, 16'h0000, 8'h81, 8'h00, HDR_BYTE, 9);
    push_frame(8'h5A, 16'h0001, 16'hFFFF, 8'h7F, 8'h40, FTR_BYTE, 9);
    wait_sent();

    add_traffic(180);
    wait_sent();

    // no idling on either side
    calm = 1'b1;
    add_traffic(150);
    wait_sent();
    calm = 1'b0;

    // long output stall while bytes keep coming
    hold_go = 1'b1;
    add_traffic(190);
    wait_sent();

    while (motion_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
